@@ design/uniform_grid_bilinear_interp_macros.svh @@
// Assertion macros shared by the bilinear interpolation block.
`ifndef UNIFORM_GRID_BILINEAR_INTERP_MACROS_SVH
`define UNIFORM_GRID_BILINEAR_INTERP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UBI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UBI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ubi_pkg.sv @@
// Shared types and constants of the bilinear interpolation block.
package ubi_pkg;

  localparam int unsigned GRID_X_DEF = 64;
  localparam int unsigned GRID_Y_DEF = 64;

  // A weight of exactly one in 16 fraction bits.
  localparam logic [16:0] W_ONE = 17'h10000;

  typedef enum logic [2:0] {
    CFG_X_MIN         = 3'd0,
    CFG_X_MAX         = 3'd1,
    CFG_Y_MIN         = 3'd2,
    CFG_Y_MAX         = 3'd3,
    CFG_X_INV_SPACING = 3'd4,
    CFG_Y_INV_SPACING = 3'd5,
    CFG_DOMAIN_MODE   = 3'd6,
    CFG_OUTSIDE_VALUE = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_IDX  = 2'd1,
    SEL_LAST = 2'd2
  } sel_e;

  // Position of a coordinate against the domain bounds of its axis.
  typedef struct packed {
    logic lt_lo;
    logic le_lo;
    logic gt_hi;
    logic ge_hi;
  } axis_flags_t;

endpackage

@@ design/ubi_if.sv @@
// Valid/ready channel interfaces for query words and result words.
interface ubi_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [5:0]  grid_row;
  logic [5:0]  grid_col;
  logic signed [31:0] entry_value;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;

  modport source (output valid, func, grid_row, grid_col, entry_value, x_coord, y_coord,
                  input ready);
  modport sink (input valid, func, grid_row, grid_col, entry_value, x_coord, y_coord,
                output ready);
endinterface

interface ubi_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] interp_value;
  logic        outside;

  modport source (output valid, interp_value, outside, input ready);
  modport sink (input valid, interp_value, outside, output ready);
endinterface

@@ design/ubi_ram.sv @@
// Simple dual-port RAM with one write port and a registered read port.
module ubi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ubi_axis.sv @@
// Three-stage axis unit: offset, scale by inverse spacing, cell index and weight.
module ubi_axis #(
  parameter int unsigned N = 64,
  localparam int unsigned IW = $clog2(N)
) (
  input  logic                 clk_i,
  input  logic [2:0]           en_i,
  input  logic signed [31:0]   coord_i,
  input  logic signed [31:0]   lo_i,
  input  logic signed [31:0]   hi_i,
  input  logic [31:0]          inv_i,
  output logic [IW-1:0]        idx_o,
  output logic [16:0]          w_o,
  output ubi_pkg::axis_flags_t flags_o
);

  logic signed [32:0] diff;
  logic [31:0] dpos_d, dpos_a_q;
  ubi_pkg::axis_flags_t flags_d, flags_a_q, flags_b_q, flags_c_q;
  logic [63:0] s_d, s_b_q;
  logic [32:0] ceil_v, idx_w, idx_m1;
  logic [IW-1:0] idx_d, idx_c_q;
  logic [16:0] w_d, w_c_q;

  // Stage A: offset from the lower bound and bound comparisons.
  always_comb begin
    diff = 33'(coord_i) - 33'(lo_i);
    dpos_d = (!diff[32] && (diff != '0)) ? diff[31:0] : '0;
    flags_d.lt_lo = coord_i < lo_i;
    flags_d.le_lo = coord_i <= lo_i;
    flags_d.gt_hi = coord_i > hi_i;
    flags_d.ge_hi = coord_i >= hi_i;
  end

  // Stage B: scaled position in Q32.32.
  assign s_d = {32'd0, dpos_a_q} * {32'd0, inv_i};

  // Stage C: ceiling, correction of the index and saturated weight.
  always_comb begin
    ceil_v = {1'b0, s_b_q[63:32]} + 33'(s_b_q[31:0] != '0);
    if (ceil_v == '0) begin
      idx_w = 33'd1;
    end else if (ceil_v > 33'(N - 1)) begin
      idx_w = 33'(N - 1);
    end else begin
      idx_w = ceil_v;
    end
    idx_d = idx_w[IW-1:0];
    idx_m1 = idx_w - 33'd1;
    if ({1'b0, s_b_q[63:32]} < idx_m1) begin
      w_d = '0;
    end else if ({1'b0, s_b_q[63:32]} > idx_m1) begin
      w_d = ubi_pkg::W_ONE;
    end else begin
      w_d = {1'b0, s_b_q[31:16]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dpos_a_q  <= dpos_d;
      flags_a_q <= flags_d;
    end
    if (en_i[1]) begin
      s_b_q     <= s_d;
      flags_b_q <= flags_a_q;
    end
    if (en_i[2]) begin
      idx_c_q   <= idx_d;
      w_c_q     <= w_d;
      flags_c_q <= flags_b_q;
    end
  end

  assign idx_o   = idx_c_q;
  assign w_o     = w_c_q;
  assign flags_o = flags_c_q;

endmodule

@@ design/ubi_blend.sv @@
// Three-stage blend of four corner values: X products, X sums, Y products.
module ubi_blend (
  input  logic               clk_i,
  input  logic [2:0]         en_i,
  input  logic signed [31:0] e_ll_i,
  input  logic signed [31:0] e_hl_i,
  input  logic signed [31:0] e_lh_i,
  input  logic signed [31:0] e_hh_i,
  input  logic [16:0]        wx_i,
  input  logic [16:0]        wy_i,
  output logic signed [63:0] q0_o,
  output logic signed [63:0] q1_o
);

  logic [16:0] wxbar, wybar;
  logic signed [49:0] pa_d, pb_d, pc_d, pd_d;
  logic signed [49:0] pa_q, pb_q, pc_q, pd_q;
  logic [16:0] wy_e_q, wy_f_q;
  logic signed [50:0] r0_q, r1_q;
  logic signed [68:0] m0, m1;
  logic signed [63:0] q0_q, q1_q;

  assign wxbar = ubi_pkg::W_ONE - wx_i;
  assign wybar = ubi_pkg::W_ONE - wy_f_q;

  assign pa_d = e_ll_i * $signed({1'b0, wxbar});
  assign pb_d = e_hl_i * $signed({1'b0, wx_i});
  assign pc_d = e_lh_i * $signed({1'b0, wxbar});
  assign pd_d = e_hh_i * $signed({1'b0, wx_i});

  assign m0 = r0_q * $signed({1'b0, wybar});
  assign m1 = r1_q * $signed({1'b0, wy_f_q});

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      pc_q   <= pc_d;
      pd_q   <= pd_d;
      wy_e_q <= wy_i;
    end
    if (en_i[1]) begin
      r0_q   <= 51'(pa_q) + 51'(pb_q);
      r1_q   <= 51'(pc_q) + 51'(pd_q);
      wy_f_q <= wy_e_q;
    end
    if (en_i[2]) begin
      q0_q <= m0[63:0];
      q1_q <= m1[63:0];
    end
  end

  assign q0_o = q0_q;
  assign q1_o = q1_q;

endmodule

@@ design/uniform_grid_bilinear_interp.sv @@
// Bilinear interpolation over a uniform grid: top level with banked table and control.
// A query word passes through eight pipeline stages, A to H, on its way to the result
// channel; write words leave no result.
// Throughput: one word per cycle; a stage holds only while the one after it is full and
// stalled, so bubbles close up and a waiting result blocks input once all eight are full.
// Reset clears the valid bits and loads the configuration defaults; the table keeps its data.
module uniform_grid_bilinear_interp #(
  parameter int unsigned GRID_X = ubi_pkg::GRID_X_DEF,
  parameter int unsigned GRID_Y = ubi_pkg::GRID_Y_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ubi_in_if.sink      item_i,
  ubi_out_if.source   result_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned XW    = $clog2(GRID_X);
  localparam int unsigned YW    = $clog2(GRID_Y);
  localparam int unsigned HX    = (GRID_X + 1) / 2;
  localparam int unsigned HY    = (GRID_Y + 1) / 2;
  localparam int unsigned DEPTH = HX * HY;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NST   = 8;

  // Configuration registers.
  logic signed [31:0] x_min_q, x_max_q, y_min_q, y_max_q, outside_value_q;
  logic [31:0] x_inv_q, y_inv_q;
  logic        mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q         <= 32'sd0;
      x_max_q         <= 32'sd4128768;
      y_min_q         <= 32'sd0;
      y_max_q         <= 32'sd4128768;
      x_inv_q         <= 32'd65536;
      y_inv_q         <= 32'd65536;
      mode_q          <= 1'b0;
      outside_value_q <= 32'sd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ubi_pkg::CFG_X_MIN:         x_min_q <= cfg_wdata_i;
        ubi_pkg::CFG_X_MAX:         x_max_q <= cfg_wdata_i;
        ubi_pkg::CFG_Y_MIN:         y_min_q <= cfg_wdata_i;
        ubi_pkg::CFG_Y_MAX:         y_max_q <= cfg_wdata_i;
        ubi_pkg::CFG_X_INV_SPACING: x_inv_q <= cfg_wdata_i;
        ubi_pkg::CFG_Y_INV_SPACING: y_inv_q <= cfg_wdata_i;
        ubi_pkg::CFG_DOMAIN_MODE:   mode_q  <= cfg_wdata_i[0];
        ubi_pkg::CFG_OUTSIDE_VALUE: outside_value_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage enables. A stage loads when it is empty or when the
  // stage after it loads too, so the chain is evaluated from the output backwards.
  logic [NST-1:0] v_q, en;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || result_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign item_i.ready = en[0];

  logic func_a_q, func_b_q, func_c_q, func_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          if (k == 0) begin
            v_q[k] <= item_i.valid;
          end else if (k == 4) begin
            // Write words finish in the table stage and go no further.
            v_q[k] <= v_q[3] && func_d_q;
          end else begin
            v_q[k] <= v_q[k-1];
          end
        end
      end
    end
  end

  // Write word fields travel alongside the axis units until the table stage.
  logic [31:0] row32, col32;
  logic          wok_a_q, wok_b_q, wok_c_q;
  logic [XW-1:0] wrow_a_q, wrow_b_q, wrow_c_q;
  logic [YW-1:0] wcol_a_q, wcol_b_q, wcol_c_q;
  logic [31:0]   wval_a_q, wval_b_q, wval_c_q;

  assign row32 = 32'(item_i.grid_row);
  assign col32 = 32'(item_i.grid_col);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      func_a_q <= item_i.func;
      wok_a_q  <= (row32 < 32'(GRID_X)) && (col32 < 32'(GRID_Y));
      wrow_a_q <= row32[XW-1:0];
      wcol_a_q <= col32[YW-1:0];
      wval_a_q <= item_i.entry_value;
    end
    if (en[1]) begin
      func_b_q <= func_a_q;
      wok_b_q  <= wok_a_q;
      wrow_b_q <= wrow_a_q;
      wcol_b_q <= wcol_a_q;
      wval_b_q <= wval_a_q;
    end
    if (en[2]) begin
      func_c_q <= func_b_q;
      wok_c_q  <= wok_b_q;
      wrow_c_q <= wrow_b_q;
      wcol_c_q <= wcol_b_q;
      wval_c_q <= wval_b_q;
    end
  end

  // Axis units, stages A to C.
  logic [XW-1:0] xi_c;
  logic [YW-1:0] yj_c;
  logic [16:0]   wx_c, wy_c;
  ubi_pkg::axis_flags_t xf_c, yf_c;

  ubi_axis #(.N(GRID_X)) u_axis_x (
    .clk_i   (clk_i),
    .en_i    (en[2:0]),
    .coord_i (item_i.x_coord),
    .lo_i    (x_min_q),
    .hi_i    (x_max_q),
    .inv_i   (x_inv_q),
    .idx_o   (xi_c),
    .w_o     (wx_c),
    .flags_o (xf_c)
  );

  ubi_axis #(.N(GRID_Y)) u_axis_y (
    .clk_i   (clk_i),
    .en_i    (en[2:0]),
    .coord_i (item_i.y_coord),
    .lo_i    (y_min_q),
    .hi_i    (y_max_q),
    .inv_i   (y_inv_q),
    .idx_o   (yj_c),
    .w_o     (wy_c),
    .flags_o (yf_c)
  );

  // Domain rules. In the fixed-value mode any point beyond a bound takes the configured
  // value. In the edge mode the point takes one table entry whose row and column come
  // from the lower edge, the cell index or the upper edge; only points strictly inside,
  // or on the upper X bound, are interpolated.
  logic          fix_c, edge_c;
  ubi_pkg::sel_e rsel, csel;
  logic [XW-1:0] erow, ra, rb;
  logic [YW-1:0] ecol, ca, cb;

  always_comb begin
    fix_c  = !mode_q && (xf_c.lt_lo || yf_c.lt_lo || xf_c.gt_hi || yf_c.gt_hi);
    edge_c = mode_q;
    rsel   = ubi_pkg::SEL_IDX;
    csel   = ubi_pkg::SEL_IDX;
    if (xf_c.le_lo && yf_c.le_lo) begin
      rsel = ubi_pkg::SEL_ZERO;  csel = ubi_pkg::SEL_ZERO;
    end else if (xf_c.le_lo && !yf_c.ge_hi) begin
      rsel = ubi_pkg::SEL_ZERO;  csel = ubi_pkg::SEL_IDX;
    end else if (xf_c.le_lo) begin
      rsel = ubi_pkg::SEL_ZERO;  csel = ubi_pkg::SEL_LAST;
    end else if (!xf_c.gt_hi && yf_c.le_lo) begin
      rsel = ubi_pkg::SEL_IDX;   csel = ubi_pkg::SEL_ZERO;
    end else if (!xf_c.gt_hi && yf_c.ge_hi) begin
      rsel = ubi_pkg::SEL_IDX;   csel = ubi_pkg::SEL_LAST;
    end else if (xf_c.gt_hi && yf_c.le_lo) begin
      rsel = ubi_pkg::SEL_LAST;  csel = ubi_pkg::SEL_ZERO;
    end else if (xf_c.gt_hi && !yf_c.gt_hi) begin
      rsel = ubi_pkg::SEL_LAST;  csel = ubi_pkg::SEL_IDX;
    end else if (xf_c.gt_hi) begin
      rsel = ubi_pkg::SEL_LAST;  csel = ubi_pkg::SEL_LAST;
    end else begin
      edge_c = 1'b0;
    end

    case (rsel)
      ubi_pkg::SEL_ZERO: erow = '0;
      ubi_pkg::SEL_IDX:  erow = xi_c;
      ubi_pkg::SEL_LAST: erow = XW'(GRID_X - 1);
      default:           erow = '0;
    endcase
    case (csel)
      ubi_pkg::SEL_ZERO: ecol = '0;
      ubi_pkg::SEL_IDX:  ecol = yj_c;
      ubi_pkg::SEL_LAST: ecol = YW'(GRID_Y - 1);
      default:           ecol = '0;
    endcase

    // Row and column pairs to fetch: the cell's two corners, or the one edge entry twice.
    ra = edge_c ? erow : xi_c - XW'(1);
    rb = edge_c ? erow : xi_c;
    ca = edge_c ? ecol : yj_c - YW'(1);
    cb = edge_c ? ecol : yj_c;
  end

  // Table in four banks by row and column parity, so the four corners of any cell lie
  // in different banks and are fetched in the same cycle. Bank index is {row[0], col[0]}.
  logic        wr_go;
  logic [3:0]  bank_we;
  logic [31:0] bank_rd [4];

  assign wr_go = en[3] && v_q[2] && !func_c_q && wok_c_q;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [XW-1:0] rrow;
    logic [YW-1:0] rcol;
    logic [AW-1:0] waddr, raddr;

    assign rrow  = (ra[0] == 1'(b >> 1)) ? ra : rb;
    assign rcol  = (ca[0] == 1'(b & 1)) ? ca : cb;
    assign raddr = AW'(32'(rrow >> 1) * 32'(HY) + 32'(rcol >> 1));
    assign waddr = AW'(32'(wrow_c_q >> 1) * 32'(HY) + 32'(wcol_c_q >> 1));
    assign bank_we[b] = wr_go && (wrow_c_q[0] == 1'(b >> 1)) && (wcol_c_q[0] == 1'(b & 1));

    ubi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (waddr),
      .wdata_i (wval_c_q),
      .re_i    (en[3]),
      .raddr_i (raddr),
      .rdata_o (bank_rd[b])
    );
  end

  // Stage D side registers, beside the bank read data.
  logic        fix_d_q, edge_d_q, er_d_q, ec_d_q, xp_d_q, yp_d_q;
  logic [16:0] wx_d_q, wy_d_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      func_d_q <= func_c_q;
      fix_d_q  <= fix_c;
      edge_d_q <= edge_c;
      er_d_q   <= erow[0];
      ec_d_q   <= ecol[0];
      xp_d_q   <= xi_c[0];
      yp_d_q   <= yj_c[0];
      wx_d_q   <= wx_c;
      wy_d_q   <= wy_c;
    end
  end

  // Corner selection from the banks: low/high refer to index i-1/i and j-1/j.
  logic signed [31:0] e_ll, e_hl, e_lh, e_hh, e_edge;

  assign e_ll   = bank_rd[{!xp_d_q, !yp_d_q}];
  assign e_hl   = bank_rd[{xp_d_q, !yp_d_q}];
  assign e_lh   = bank_rd[{!xp_d_q, yp_d_q}];
  assign e_hh   = bank_rd[{xp_d_q, yp_d_q}];
  assign e_edge = bank_rd[{er_d_q, ec_d_q}];

  // Stages E to G: blend datapath; the rule flags and edge value ride alongside.
  logic signed [63:0] q0_g, q1_g;

  ubi_blend u_blend (
    .clk_i  (clk_i),
    .en_i   (en[6:4]),
    .e_ll_i (e_ll),
    .e_hl_i (e_hl),
    .e_lh_i (e_lh),
    .e_hh_i (e_hh),
    .wx_i   (wx_d_q),
    .wy_i   (wy_d_q),
    .q0_o   (q0_g),
    .q1_o   (q1_g)
  );

  logic        fix_e_q, fix_f_q, fix_g_q, edge_e_q, edge_f_q, edge_g_q;
  logic [31:0] ev_e_q, ev_f_q, ev_g_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      fix_e_q  <= fix_d_q;
      edge_e_q <= edge_d_q;
      ev_e_q   <= e_edge;
    end
    if (en[5]) begin
      fix_f_q  <= fix_e_q;
      edge_f_q <= edge_e_q;
      ev_f_q   <= ev_e_q;
    end
    if (en[6]) begin
      fix_g_q  <= fix_f_q;
      edge_g_q <= edge_f_q;
      ev_g_q   <= ev_f_q;
    end
  end

  // Stage H: final sum, floor to Q16.16 and result selection. The sum is a convex
  // combination of the corners, so it never overflows 64 bits.
  logic signed [63:0] r_sum;
  logic [31:0] val_d, val_q;
  logic        out_d, out_q;

  always_comb begin
    r_sum = q0_g + q1_g;
    if (fix_g_q) begin
      val_d = outside_value_q;
      out_d = 1'b1;
    end else if (edge_g_q) begin
      val_d = ev_g_q;
      out_d = 1'b1;
    end else begin
      val_d = r_sum[63:32];
      out_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      val_q <= val_d;
      out_q <= out_d;
    end
  end

  assign result_o.valid        = v_q[7];
  assign result_o.interp_value = val_q;
  assign result_o.outside      = out_q;

`include "uniform_grid_bilinear_interp_macros.svh"

  `UBI_ASSERT_NEXT(a_write_no_result, en[4] && v_q[3] && !func_d_q, !v_q[4], "write word left a result")
  `UBI_ASSERT_IMPL(a_bank_we_onehot, 1'b1, $onehot0(bank_we), "more than one bank written")
  `UBI_ASSERT_IMPL(a_index_nonzero, v_q[2], (xi_c != '0) && (yj_c != '0), "corner index is zero")
  `UBI_ASSERT_NEXT(a_stall_holds, v_q[7] && !result_o.ready, v_q[7] && $stable(val_q), "stalled result lost")

endmodule

@@ verif/ubi_tb_pkg.sv @@
// Word kinds and result record shared by the testbench top and its checker.
package ubi_tb_pkg;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic MODE_FIXED = 1'b0;
  localparam logic MODE_EDGE  = 1'b1;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic               outside;
  } interp_result_t;

endpackage

@@ verif/ubi_checker.sv @@
// Checker that predicts interpolation results from accepted words and compares them.
module ubi_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ubi_in_if           item,
  ubi_out_if          result,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output int          fail_count,
  output int          pending
);

  localparam int NX = 64;
  localparam int NY = 64;

  logic [31:0] grid_mem [NX*NY];
  logic signed [31:0] x_lo, x_hi, y_lo, y_hi, out_val;
  logic [31:0] x_inv, y_inv;
  logic        edge_mode;
  ubi_tb_pkg::interp_result_t interp_q[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    fail_count++;
  endtask

  function automatic longint grid_at(input logic [63:0] r, input logic [63:0] c);
    return longint'(signed'(grid_mem[r * NY + c]));
  endfunction

  // Upper corner index of one axis, clamped to [1, n-1], and its weight with 16 fraction bits.
  function automatic logic [63:0] corner_index(input logic signed [31:0] c,
                                               input logic signed [31:0] lo,
                                               input logic [31:0] inv, input logic [63:0] n,
                                               output longint w16);
    logic signed [63:0] d;
    logic [63:0] s, idx, base, w;
    d = 64'(c) - 64'(lo);
    s = (d > 0) ? 64'(d) * {32'd0, inv} : 64'd0;
    idx = (s >> 32) + 64'(s[31:0] != 0);
    if (idx < 1) idx = 1;
    if (idx > n - 1) idx = n - 1;
    base = (idx - 1) << 32;
    if (s <= base) w = 0;
    else if (s - base >= 64'h1_0000_0000) w = 64'h1_0000_0000;
    else w = s - base;
    w16 = longint'(w[32:16]);
    return idx;
  endfunction

  function automatic ubi_tb_pkg::interp_result_t interpolate(input logic signed [31:0] xc,
                                                             input logic signed [31:0] yc);
    ubi_tb_pkg::interp_result_t res;
    logic [63:0] i, j;
    longint wx, wy, r0, r1, r;
    i = corner_index(xc, x_lo, x_inv, NX, wx);
    j = corner_index(yc, y_lo, y_inv, NY, wy);
    res.outside = 1'b1;
    if (edge_mode == ubi_tb_pkg::MODE_FIXED) begin
      if (xc < x_lo || yc < y_lo || xc > x_hi || yc > y_hi) begin
        res.interp_value = out_val;
        return res;
      end
    end else begin
      if (xc <= x_lo && yc <= y_lo) r = grid_at(0, 0);
      else if (xc <= x_lo && yc < y_hi) r = grid_at(0, j);
      else if (xc <= x_lo) r = grid_at(0, NY - 1);
      else if (xc <= x_hi && yc <= y_lo) r = grid_at(i, 0);
      else if (xc <= x_hi && yc >= y_hi) r = grid_at(i, NY - 1);
      else if (yc <= y_lo && xc > x_hi) r = grid_at(NX - 1, 0);
      else if (yc <= y_hi && xc > x_hi) r = grid_at(NX - 1, j);
      else if (xc > x_hi) r = grid_at(NX - 1, NY - 1);
      else res.outside = 1'b0;
      if (res.outside) begin
        res.interp_value = r[31:0];
        return res;
      end
    end
    r0 = grid_at(i - 1, j - 1) * (65536 - wx) + grid_at(i, j - 1) * wx;
    r1 = grid_at(i - 1, j) * (65536 - wx) + grid_at(i, j) * wx;
    r = r0 * (65536 - wy) + r1 * wy;
    res.interp_value = r[63:32];
    res.outside = 1'b0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ubi_tb_pkg::interp_result_t want;
    if (!rst_ni) begin
      x_lo = 0; x_hi = 32'd4128768; y_lo = 0; y_hi = 32'd4128768;
      x_inv = 32'd65536; y_inv = 32'd65536; edge_mode = ubi_tb_pkg::MODE_FIXED; out_val = 0;
      fail_count = 0;
      pending = 0;
    end else begin
      if (cfg_we_i) begin
        case (ubi_pkg::cfg_idx_e'(cfg_idx_i))
          ubi_pkg::CFG_X_MIN:         x_lo = cfg_wdata_i;
          ubi_pkg::CFG_X_MAX:         x_hi = cfg_wdata_i;
          ubi_pkg::CFG_Y_MIN:         y_lo = cfg_wdata_i;
          ubi_pkg::CFG_Y_MAX:         y_hi = cfg_wdata_i;
          ubi_pkg::CFG_X_INV_SPACING: x_inv = cfg_wdata_i;
          ubi_pkg::CFG_Y_INV_SPACING: y_inv = cfg_wdata_i;
          ubi_pkg::CFG_DOMAIN_MODE:   edge_mode = cfg_wdata_i[0];
          ubi_pkg::CFG_OUTSIDE_VALUE: out_val = cfg_wdata_i;
          default: ;
        endcase
      end
      if (item.valid && item.ready) begin
        if (item.func == ubi_tb_pkg::FUNC_WRITE)
          grid_mem[item.grid_row * NY + item.grid_col] = item.entry_value;
        else interp_q.push_back(interpolate(item.x_coord, item.y_coord));
      end
      if (result.valid && result.ready) begin
        if (interp_q.size() == 0) begin
          report("unexpected result word", result.interp_value, '0);
        end else begin
          want = interp_q.pop_front();
          if (result.interp_value !== want.interp_value)
            report("interp_value", result.interp_value, want.interp_value);
          if (result.outside !== want.outside)
            report("outside", 32'(result.outside), 32'(want.outside));
        end
      end
      pending = interp_q.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
// Testbench top: drives words and configuration into the interpolator and gives the verdict.
module testbench;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  int          fail_count;
  int          pending;
  bit          no_gaps;

  // Our own copy of the domain bounds, used only to aim random query points.
  logic signed [31:0] dom_x_lo, dom_x_hi, dom_y_lo, dom_y_hi;

  ubi_in_if  item_ch ();
  ubi_out_if result_ch ();

  uniform_grid_bilinear_interp dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_ch),
    .result_o   (result_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  ubi_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item       (item_ch),
    .result     (result_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // A generous ceiling on the run; a correct run finishes well inside it.
  initial begin
    #6000000;
    $display("uniform_grid_bilinear_interp regression: fail");
    $finish;
  end

  // Length of the pause before the next word: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The result side stalls in runs: mostly short, a few long, with long open stretches.
  initial begin
    int run_left;
    logic level;
    result_ch.ready = 1'b0;
    run_left = 0;
    level = 1'b1;
    forever begin
      @(negedge clk_i);
      if (run_left == 0) begin
        level = ($urandom_range(0, 2) != 0);
        run_left = level ? $urandom_range(1, 60)
                         : (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3));
      end
      result_ch.ready = level;
      run_left--;
    end
  end

  // Presents one word at a falling edge and holds it until the block takes it.
  task automatic send_word(input logic f, input logic [5:0] row, input logic [5:0] col,
                           input logic [31:0] val, input logic [31:0] xc,
                           input logic [31:0] yc);
    int g;
    g = gap_len();
    if (g > 0) begin
      item_ch.valid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    item_ch.valid       = 1'b1;
    item_ch.func        = f;
    item_ch.grid_row    = row;
    item_ch.grid_col    = col;
    item_ch.entry_value = val;
    item_ch.x_coord     = xc;
    item_ch.y_coord     = yc;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_entry(input logic [5:0] row, input logic [5:0] col,
                             input logic [31:0] val);
    send_word(ubi_tb_pkg::FUNC_WRITE, row, col, val, $urandom, $urandom);
  endtask

  task automatic query(input logic [31:0] xc, input logic [31:0] yc);
    send_word(ubi_tb_pkg::FUNC_QUERY, 6'($urandom), 6'($urandom), $urandom, xc, yc);
  endtask

  // Registers change only with the pipeline drained; the extra cycles cover write words
  // still in flight, which leave no result behind them.
  task automatic set_reg(input ubi_pkg::cfg_idx_e idx, input logic [31:0] data);
    item_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      ubi_pkg::CFG_X_MIN: dom_x_lo = data;
      ubi_pkg::CFG_X_MAX: dom_x_hi = data;
      ubi_pkg::CFG_Y_MIN: dom_y_lo = data;
      ubi_pkg::CFG_Y_MAX: dom_y_hi = data;
      default: ;
    endcase
  endtask

  task automatic set_domain(input logic [31:0] xl, input logic [31:0] xh,
                            input logic [31:0] yl, input logic [31:0] yh,
                            input logic [31:0] xs, input logic [31:0] ys,
                            input logic md, input logic [31:0] ov);
    set_reg(ubi_pkg::CFG_X_MIN, xl);
    set_reg(ubi_pkg::CFG_X_MAX, xh);
    set_reg(ubi_pkg::CFG_Y_MIN, yl);
    set_reg(ubi_pkg::CFG_Y_MAX, yh);
    set_reg(ubi_pkg::CFG_X_INV_SPACING, xs);
    set_reg(ubi_pkg::CFG_Y_INV_SPACING, ys);
    set_reg(ubi_pkg::CFG_DOMAIN_MODE, {31'd0, md});
    set_reg(ubi_pkg::CFG_OUTSIDE_VALUE, ov);
  endtask

  // A coordinate aimed at one axis: inside the domain, right on or next to a bound,
  // or anywhere at all.
  function automatic logic [31:0] pick_coord(input logic signed [31:0] lo,
                                             input logic signed [31:0] hi);
    longint span;
    int r;
    r = $urandom_range(0, 9);
    span = longint'(hi) - longint'(lo) + 1;
    if (r < 6 && span > 0) return 32'(longint'(lo) + longint'({$urandom, $urandom} % span));
    if (r == 6) return lo + 32'($urandom_range(0, 2)) - 32'd1;
    if (r == 7) return hi + 32'($urandom_range(0, 2)) - 32'd1;
    return $urandom;
  endfunction

  // Random words: mostly queries, with table rewrites spread among them.
  task automatic random_words(input int count);
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) write_entry(6'($urandom), 6'($urandom), $urandom);
      else query(pick_coord(dom_x_lo, dom_x_hi), pick_coord(dom_y_lo, dom_y_hi));
    end
  endtask

  initial begin
    int r, c;
    rst_ni = 1'b0;
    no_gaps = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = ubi_pkg::CFG_X_MIN;
    cfg_wdata_i = '0;
    item_ch.valid = 1'b0;
    item_ch.func = ubi_tb_pkg::FUNC_WRITE;
    item_ch.grid_row = '0;
    item_ch.grid_col = '0;
    item_ch.entry_value = '0;
    item_ch.x_coord = '0;
    item_ch.y_coord = '0;
    dom_x_lo = 0; dom_x_hi = 32'd4128768; dom_y_lo = 0; dom_y_hi = 32'd4128768;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // The table holds nothing defined after reset. Only rows and columns 0 to 15 and the
    // last two of each are filled: every domain below keeps its inside cells within the
    // low block, and the edge rules add only row and column zero and the last ones.
    // Back-to-back words here give a stretch with no idling at input.
    no_gaps = 1'b1;
    for (r = 0; r < 64; r++)
      for (c = 0; c < 64; c++)
        if ((r < 16 || r >= 62) && (c < 16 || c >= 62)) write_entry(6'(r), 6'(c), $urandom);
    no_gaps = 1'b0;

    // Directed words under the reset settings: extreme entry values at the corners,
    // points on each bound, just past them, and the extreme coordinates.
    write_entry(0, 0, 32'h7fff_ffff);
    write_entry(0, 1, 32'h8000_0000);
    write_entry(1, 0, 32'h8000_0000);
    write_entry(1, 1, 32'h7fff_ffff);
    write_entry(63, 63, 32'h8000_0000);
    query(32'h0000_8000, 32'h0000_4000);
    query(32'h0, 32'h0);
    query(32'd4128768, 32'd4128768);
    query(32'hffff_ffff, 32'h0);
    query(32'h0, 32'd4128769);
    query(32'h8000_0000, 32'h7fff_ffff);
    query(32'h7fff_ffff, 32'h8000_0000);
    query(32'h0001_0000, 32'h0002_0000);
    query(32'h003e_ffff, 32'h0000_0001);
    set_reg(ubi_pkg::CFG_DOMAIN_MODE, {31'd0, ubi_tb_pkg::MODE_EDGE});
    query(32'hffff_0000, 32'hffff_0000);
    query(32'hffff_0000, 32'h0008_8000);
    query(32'hffff_0000, 32'h7fff_ffff);
    query(32'h0008_8000, 32'h8000_0000);
    query(32'h0008_8000, 32'd4128768);
    query(32'h7fff_ffff, 32'h0);
    query(32'h7fff_ffff, 32'h000c_4000);
    query(32'h7fff_ffff, 32'h7fff_ffff);
    query(32'h000c_4000, 32'h0009_c000);

    // A domain of fifteen unit cells per axis with edge entries outside.
    set_domain(32'h0, 32'h000f_0000, 32'h0, 32'h000f_0000,
               32'd65536, 32'd65536, ubi_tb_pkg::MODE_EDGE, 32'h0);
    random_words(110);

    // Full-range domain with a tiny inverse spacing: the widest offsets still land in low cells.
    set_domain(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
               32'd15, 32'd15, ubi_tb_pkg::MODE_FIXED, 32'h8000_0000);
    random_words(100);

    // A domain only fifteen raw steps wide with the largest inverse spacing.
    set_domain(32'hffff_fff8, 32'h0000_0007, 32'hffff_fff8, 32'h0000_0007,
               32'hffff_ffff, 32'hffff_ffff, ubi_tb_pkg::MODE_FIXED, 32'h8000_0000);
    random_words(100);

    // A small domain around zero with a fractional spacing, edge entries outside.
    set_domain(32'hfff8_0000, 32'h0008_0000, 32'hfffc_0000, 32'h0004_0000,
               32'd61440, 32'd122880, ubi_tb_pkg::MODE_EDGE, 32'h7fff_ffff);
    random_words(100);

    // Same domain under the fixed value, with slow spacing so weights stay fine.
    set_domain(32'hfff8_0000, 32'h0008_0000, 32'hfffc_0000, 32'h0004_0000,
               32'd1, 32'h0000_8000, ubi_tb_pkg::MODE_FIXED, 32'h1234_5678);
    random_words(100);

    // Bounds the wrong way round and zero inverse spacing: the same rules still apply.
    set_domain(32'h0010_0000, 32'hfff0_0000, 32'h7fff_ffff, 32'h8000_0000,
               32'd0, 32'd0, ubi_tb_pkg::MODE_EDGE, 32'h0);
    random_words(50);
    set_reg(ubi_pkg::CFG_DOMAIN_MODE, {31'd0, ubi_tb_pkg::MODE_FIXED});
    random_words(30);

    item_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) $display("uniform_grid_bilinear_interp regression: pass");
    else $display("uniform_grid_bilinear_interp regression: fail");
    $finish;
  end

endmodule

@@ uniform_grid_bilinear_interp.f @@
+incdir+design
design/ubi_pkg.sv
design/ubi_if.sv
design/ubi_ram.sv
design/ubi_axis.sv
design/ubi_blend.sv
design/uniform_grid_bilinear_interp.sv
verif/ubi_tb_pkg.sv
verif/ubi_checker.sv
verif/testbench.sv
